[rtl/sorted_priority_queue_assert.svh]
// Assertion macros for the sorted priority queue.
// Used by the top level; expects signals aclk and aresetn in scope.
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SPQ_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/spq_pkg.sv]
// Shared constants and types for the sorted priority queue.
// No dependencies; used by spq_cell and sorted_priority_queue.
package spq_pkg;

    localparam int DEPTH_DEFAULT         = 16;
    localparam int PAYLOAD_WIDTH_DEFAULT = 32;
    localparam int WEIGHT_W              = 32;
    localparam int STATUS_W              = 2;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_POP    = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic insert;
        logic pop;
    } cmd_t;

    // Per-cell position information derived from the entry count.
    typedef struct packed {
        logic occupied;
        logic at_tail;
    } cell_pos_t;

endpackage

[rtl/sorted_priority_queue.sv]
// Sorted priority queue: a chain of DEPTH cells kept in ascending weight order.
// The result appears in the output register in the cycle after the input transfer.
// One operation per cycle unless the output stalls; all cells compare and shift together.
// Reset clears the entry count and the output valid; the cell contents are not cleared.
// Depends on spq_pkg, spq_cell and sorted_priority_queue_assert.svh.
`include "sorted_priority_queue_assert.svh"

module sorted_priority_queue #(
    parameter int DEPTH         = spq_pkg::DEPTH_DEFAULT,
    parameter int PAYLOAD_WIDTH = spq_pkg::PAYLOAD_WIDTH_DEFAULT,
    localparam int CNT_W        = $clog2(DEPTH + 1)
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_operation,
    input  logic [spq_pkg::WEIGHT_W-1:0] s_weight,
    input  logic [PAYLOAD_WIDTH-1:0]     s_payload,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [spq_pkg::WEIGHT_W-1:0] m_out_weight,
    output logic [PAYLOAD_WIDTH-1:0]     m_out_payload,
    output logic [spq_pkg::STATUS_W-1:0] m_status,
    output logic [CNT_W-1:0]             m_occupancy
);

    // The queue lives in a row of cells. Cell 0 holds the least weight, and
    // cells at or above the entry count hold stale data that is never read.
    // An insert is resolved locally: every occupied cell compares its key
    // against the new weight. A cell whose left neighbor is at or above the
    // new weight takes that neighbor's entry (the shift to the right), and
    // the first cell at or above the new weight, or the tail cell when none
    // is, takes the new entry. Ties therefore land ahead of older equal keys.
    // A pop makes every cell take its right neighbor's entry, while the head
    // entry is captured into the output register.

    logic                         s_fire;
    logic                         m_fire;
    logic                         is_full;
    logic                         is_empty;
    logic                         insert_ok;
    logic                         pop_ok;
    spq_pkg::cmd_t                cmd;

    logic [CNT_W-1:0]             count_reg, count_next;
    logic                         m_valid_reg, m_valid_next;
    logic [spq_pkg::WEIGHT_W-1:0] m_weight_reg, m_weight_next;
    logic [PAYLOAD_WIDTH-1:0]     m_payload_reg, m_payload_next;
    logic [spq_pkg::STATUS_W-1:0] m_status_reg, m_status_next;
    logic [CNT_W-1:0]             m_occ_reg, m_occ_next;

    logic [spq_pkg::WEIGHT_W-1:0] key_arr     [DEPTH];
    logic [PAYLOAD_WIDTH-1:0]     payload_arr [DEPTH];
    logic                         ge_arr      [DEPTH];

    // The output register parts the two sides: a new transfer is taken
    // whenever the held result is gone or leaves in this same cycle.
    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;
    assign m_fire  = m_valid_reg && m_ready;

    assign is_full   = (count_reg == CNT_W'(DEPTH));
    assign is_empty  = (count_reg == '0);
    assign insert_ok = s_fire && (s_operation == spq_pkg::OP_INSERT) && !is_full;
    assign pop_ok    = s_fire && (s_operation == spq_pkg::OP_POP) && !is_empty;

    assign cmd.insert = insert_ok;
    assign cmd.pop    = pop_ok;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            spq_pkg::cell_pos_t           pos;
            logic                         left_ge;
            logic [spq_pkg::WEIGHT_W-1:0] left_key;
            logic [PAYLOAD_WIDTH-1:0]     left_payload;
            logic [spq_pkg::WEIGHT_W-1:0] right_key;
            logic [PAYLOAD_WIDTH-1:0]     right_payload;

            assign pos.occupied = (CNT_W'(gi) < count_reg);
            assign pos.at_tail  = (CNT_W'(gi) == count_reg);

            if (gi == 0) begin : g_head
                assign left_ge      = 1'b0;
                assign left_key     = '0;
                assign left_payload = '0;
            end else begin : g_body
                assign left_ge      = ge_arr[gi-1];
                assign left_key     = key_arr[gi-1];
                assign left_payload = payload_arr[gi-1];
            end

            // The last cell has no right neighbor; on a pop its entry falls
            // outside the count, so it simply keeps what it holds.
            if (gi == DEPTH - 1) begin : g_last
                assign right_key     = key_arr[gi];
                assign right_payload = payload_arr[gi];
            end else begin : g_inner
                assign right_key     = key_arr[gi+1];
                assign right_payload = payload_arr[gi+1];
            end

            spq_cell #(
                .PAYLOAD_WIDTH(PAYLOAD_WIDTH)
            ) u_cell (
                .aclk         (aclk),
                .cmd          (cmd),
                .pos          (pos),
                .new_key      (s_weight),
                .new_payload  (s_payload),
                .left_ge      (left_ge),
                .left_key     (left_key),
                .left_payload (left_payload),
                .right_key    (right_key),
                .right_payload(right_payload),
                .ge           (ge_arr[gi]),
                .key_q        (key_arr[gi]),
                .payload_q    (payload_arr[gi])
            );
        end
    endgenerate

    // Entry count and the result that each transfer produces.
    always_comb begin
        count_next     = count_reg;
        m_valid_next   = m_valid_reg;
        m_weight_next  = m_weight_reg;
        m_payload_next = m_payload_reg;
        m_status_next  = m_status_reg;
        m_occ_next     = m_occ_reg;

        if (insert_ok) begin
            count_next = count_reg + 1'b1;
        end else if (pop_ok) begin
            count_next = count_reg - 1'b1;
        end

        if (m_fire) begin
            m_valid_next = 1'b0;
        end

        if (s_fire) begin
            m_valid_next   = 1'b1;
            m_weight_next  = '0;
            m_payload_next = '0;
            m_status_next  = spq_pkg::ST_OK;
            m_occ_next     = count_next;
            if (s_operation == spq_pkg::OP_INSERT) begin
                if (is_full) begin
                    m_status_next = spq_pkg::ST_FULL;
                end
            end else begin
                if (is_empty) begin
                    m_status_next = spq_pkg::ST_EMPTY;
                end else begin
                    m_weight_next  = key_arr[0];
                    m_payload_next = payload_arr[0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        m_weight_reg  <= m_weight_next;
        m_payload_reg <= m_payload_next;
        m_status_reg  <= m_status_next;
        m_occ_reg     <= m_occ_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_out_weight  = m_weight_reg;
    assign m_out_payload = m_payload_reg;
    assign m_status      = m_status_reg;
    assign m_occupancy   = m_occ_reg;

    // The count never runs past the number of cells.
    `SPQ_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= CNT_W'(DEPTH),
        "entry count exceeds depth")

    // A successful pop removes exactly one entry.
    `SPQ_ASSERT_NEXT(a_pop_count, pop_ok, count_reg == $past(count_reg) - 1'b1,
        "pop did not decrement the entry count")

    // A dropped insert can only be reported while every cell is occupied.
    `SPQ_ASSERT_SAME(a_full_occ, m_valid_reg && (m_status_reg == spq_pkg::ST_FULL),
        m_occ_reg == CNT_W'(DEPTH), "full status with partial occupancy")

    // A pop on an empty queue reports nothing held and returns zeros.
    `SPQ_ASSERT_SAME(a_empty_zero, m_valid_reg && (m_status_reg == spq_pkg::ST_EMPTY),
        (m_occ_reg == '0) && (m_weight_reg == '0) && (m_payload_reg == '0),
        "empty status with nonzero result")

endmodule

[rtl/spq_cell.sv]
// One storage cell of the sorted priority queue chain.
// Depends on spq_pkg for the command and position structs.
module spq_cell #(
    parameter int PAYLOAD_WIDTH = spq_pkg::PAYLOAD_WIDTH_DEFAULT
) (
    input  logic                         aclk,
    input  spq_pkg::cmd_t                cmd,
    input  spq_pkg::cell_pos_t           pos,
    input  logic [spq_pkg::WEIGHT_W-1:0] new_key,
    input  logic [PAYLOAD_WIDTH-1:0]     new_payload,
    input  logic                         left_ge,
    input  logic [spq_pkg::WEIGHT_W-1:0] left_key,
    input  logic [PAYLOAD_WIDTH-1:0]     left_payload,
    input  logic [spq_pkg::WEIGHT_W-1:0] right_key,
    input  logic [PAYLOAD_WIDTH-1:0]     right_payload,
    output logic                         ge,
    output logic [spq_pkg::WEIGHT_W-1:0] key_q,
    output logic [PAYLOAD_WIDTH-1:0]     payload_q
);

    logic [spq_pkg::WEIGHT_W-1:0] key_reg, key_next;
    logic [PAYLOAD_WIDTH-1:0]     payload_reg, payload_next;

    // A held entry at or above the new key makes room for it.
    assign ge = pos.occupied && (key_reg >= new_key);

    always_comb begin
        key_next     = key_reg;
        payload_next = payload_reg;
        if (cmd.insert) begin
            if (left_ge) begin
                key_next     = left_key;
                payload_next = left_payload;
            end else if (ge || pos.at_tail) begin
                key_next     = new_key;
                payload_next = new_payload;
            end
        end else if (cmd.pop) begin
            key_next     = right_key;
            payload_next = right_payload;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg     <= key_next;
        payload_reg <= payload_next;
    end

    assign key_q     = key_reg;
    assign payload_q = payload_reg;

endmodule

[dv/sorted_priority_queue_tb.sv]
// Self-checking testbench for the sorted priority queue (depth 16, 32-bit payload).
// Drives insert and pop transfers under several handshake-pressure phases and checks each
// result against a sorted-list predictor or typed row; depends on spq_pkg, RTL top level.
`timescale 1ns / 1ps

module sorted_priority_queue_tb;

    localparam int QDEPTH          = spq_pkg::DEPTH_DEFAULT;
    localparam int PAY_W           = spq_pkg::PAYLOAD_WIDTH_DEFAULT;
    localparam int WGT_W           = spq_pkg::WEIGHT_W;
    localparam int STS_W           = spq_pkg::STATUS_W;
    localparam int OCC_W           = $clog2(QDEPTH + 1);
    localparam int CLK_PERIOD      = 10;
    localparam int RESET_CYCLES    = 7;
    localparam int ITEMS_PER_PHASE = 325;
    localparam int SETTLE_CYCLES   = 16;
    localparam int WATCHDOG_LIMIT  = 5000;

    // One result of the queue, field by field as it appears on the m_ ports.
    typedef struct packed {
        logic [WGT_W-1:0] weight;
        logic [PAY_W-1:0] payload;
        logic [STS_W-1:0] status;
        logic [OCC_W-1:0] occupancy;
    } queue_result_t;

    // One row of the directed table. A row is repeated reps times, with the payload
    // stepping by one on each repetition. Where fixed is set, the typed-in result is
    // the expectation; otherwise the predictor supplies it.
    typedef struct {
        logic             op;
        logic [WGT_W-1:0] weight;
        logic [PAY_W-1:0] payload;
        int               reps;
        bit               fixed;
        queue_result_t    result;
    } directed_row_t;

    logic             aclk          = 1'b0;
    logic             aresetn       = 1'b0;
    logic             s_valid       = 1'b0;
    logic             s_ready;
    logic             s_operation   = spq_pkg::OP_INSERT;
    logic [WGT_W-1:0] s_weight      = '0;
    logic [PAY_W-1:0] s_payload     = '0;
    logic             m_valid;
    logic             m_ready       = 1'b0;
    logic [WGT_W-1:0] m_out_weight;
    logic [PAY_W-1:0] m_out_payload;
    logic [STS_W-1:0] m_status;
    logic [OCC_W-1:0] m_occupancy;

    // Side information that travels with the item currently on the input channel.
    bit            item_fixed  = 1'b0;
    queue_result_t item_result = '0;

    // Predictor state: a sorted copy of the queue, head at index 0.
    logic [WGT_W-1:0] shadow_keys [QDEPTH];
    logic [PAY_W-1:0] shadow_pays [QDEPTH];
    int               shadow_count = 0;

    queue_result_t pending_results [$];
    directed_row_t directed_rows [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int quiet_cycles   = 0;
    int error_count    = 0;
    int insert_count   = 0;
    int pop_count      = 0;
    int full_count     = 0;
    int empty_count    = 0;
    int peak_fill      = 0;

    sorted_priority_queue #(
        .DEPTH         (QDEPTH),
        .PAYLOAD_WIDTH (PAY_W)
    ) i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_weight      (s_weight),
        .s_payload     (s_payload),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_weight  (m_out_weight),
        .m_out_payload (m_out_payload),
        .m_status      (m_status),
        .m_occupancy   (m_occupancy)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // The receiver stalls at random; the percentage is set per phase.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Prints one line per mismatch and counts every one of them.
    task automatic report_error(input string msg);
        $display("[%0t] ERROR: %s", $realtime, msg);
        error_count++;
    endtask

    // Sorted-list queue: an insert goes in front of the first entry whose weight is
    // greater than or equal, so among equal weights the newest one leaves first.
    function automatic queue_result_t queue_predict(input logic op,
                                                    input logic [WGT_W-1:0] weight,
                                                    input logic [PAY_W-1:0] payload);
        queue_result_t res;
        int            pos;
        res = '0;
        if (op == spq_pkg::OP_INSERT) begin
            if (shadow_count >= QDEPTH) begin
                // A full queue drops the insert and leaves its contents alone.
                res.status = spq_pkg::ST_FULL;
            end else begin
                pos = 0;
                while (pos < shadow_count && shadow_keys[pos] < weight) pos++;
                for (int i = shadow_count; i > pos; i--) begin
                    shadow_keys[i] = shadow_keys[i-1];
                    shadow_pays[i] = shadow_pays[i-1];
                end
                shadow_keys[pos] = weight;
                shadow_pays[pos] = payload;
                shadow_count++;
                res.status = spq_pkg::ST_OK;
            end
        end else if (shadow_count == 0) begin
            // A pop on an empty queue returns zeros and flags it.
            res.status = spq_pkg::ST_EMPTY;
        end else begin
            res.weight  = shadow_keys[0];
            res.payload = shadow_pays[0];
            for (int i = 1; i < shadow_count; i++) begin
                shadow_keys[i-1] = shadow_keys[i];
                shadow_pays[i-1] = shadow_pays[i];
            end
            shadow_count--;
            res.status = spq_pkg::ST_OK;
        end
        res.occupancy = OCC_W'(shadow_count);
        return res;
    endfunction

    // Monitor: every accepted input is predicted and queued, every accepted result is
    // checked against the oldest expectation. The expectation is queued before the
    // result check so that a combinational result would still find its entry.
    always @(posedge aclk) begin : monitor
        queue_result_t want;
        queue_result_t seen;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                want = queue_predict(s_operation, s_weight, s_payload);
                if (s_operation == spq_pkg::OP_INSERT) insert_count++;
                else pop_count++;
                if (want.status == spq_pkg::ST_FULL) full_count++;
                if (want.status == spq_pkg::ST_EMPTY) empty_count++;
                if (shadow_count > peak_fill) peak_fill = shadow_count;
                if (item_fixed) want = item_result;
                pending_results.push_back(want);
            end
            if (m_valid && m_ready) begin
                seen = '{m_out_weight, m_out_payload, m_status, m_occupancy};
                if (pending_results.size() == 0) begin
                    report_error("result transfer with no expected result waiting");
                end else begin
                    want = pending_results.pop_front();
                    if (seen.weight !== want.weight)
                        report_error($sformatf("out_weight got %h expected %h",
                                               seen.weight, want.weight));
                    if (seen.payload !== want.payload)
                        report_error($sformatf("out_payload got %h expected %h",
                                               seen.payload, want.payload));
                    if (seen.status !== want.status)
                        report_error($sformatf("status got %0d expected %0d",
                                               seen.status, want.status));
                    if (seen.occupancy !== want.occupancy)
                        report_error($sformatf("occupancy got %0d expected %0d",
                                               seen.occupancy, want.occupancy));
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles = 0;
            else quiet_cycles++;
        end
    end

    // Watchdog: a run that stops making progress is a failure.
    initial begin : watchdog
        while (quiet_cycles < WATCHDOG_LIMIT) @(posedge aclk);
        $display("[%0t] ERROR: no transfer for %0d cycles", $realtime, WATCHDOG_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    // Offers one item and returns at the clock edge at which it is accepted. The
    // sender may idle first; valid only drops during such a gap, so it is never
    // lowered and raised within the same time step.
    task automatic send_item(input logic op, input logic [WGT_W-1:0] weight,
                             input logic [PAY_W-1:0] payload, input bit fixed,
                             input queue_result_t result);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            s_operation <= logic'($urandom_range(1));
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_operation <= op;
        s_weight    <= weight;
        s_payload   <= payload;
        item_fixed  <= fixed;
        item_result <= result;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Holds the sender off until every expected result has come back. The queue is
    // sampled on the falling edge, away from the monitor's updates.
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending_results.size() != 0);
        @(posedge aclk);
    endtask

    // Weights: many small values to force ties, some extremes, some 16.16 values with
    // a fraction of zero or one half, and the rest fully random.
    function automatic logic [WGT_W-1:0] pick_weight();
        logic [WGT_W-1:0] w;
        case ($urandom_range(9))
            0, 1, 2, 3: w = WGT_W'($urandom_range(7));
            4: begin
                case ($urandom_range(3))
                    0: w = '0;
                    1: w = '1;
                    2: w = 32'h7FFF_FFFF;
                    default: w = 32'h8000_0000;
                endcase
            end
            5, 6: w = {16'($urandom_range(255)), 16'($urandom_range(1) ? 16'h8000 : 16'h0)};
            default: w = $urandom;
        endcase
        return w;
    endfunction

    // Random traffic in bursts, each burst leaning toward inserts, toward pops or
    // balanced, so the queue keeps swinging between empty and full.
    task automatic run_random(input int count, input bit mid_drain);
        int            burst_left;
        int            insert_pct;
        logic          op;
        queue_result_t none;
        burst_left = 0;
        insert_pct = 50;
        none = '0;
        for (int n = 0; n < count; n++) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(10, 40);
                case ($urandom_range(2))
                    0: insert_pct = 85;
                    1: insert_pct = 15;
                    default: insert_pct = 50;
                endcase
            end
            burst_left--;
            op = ($urandom_range(99) < insert_pct) ? spq_pkg::OP_INSERT : spq_pkg::OP_POP;
            send_item(op, pick_weight(), PAY_W'($urandom), 1'b0, none);
            if (mid_drain && n == count / 2) drain_results();
        end
        drain_results();
    endtask

    initial begin : stimulus
        directed_row_t row;

        // Directed table. Typed results cover reset, the extreme weights and both
        // error codes; the tie-breaking and fill rows lean on the predictor.
        directed_rows.push_back('{spq_pkg::OP_POP, '0, '0, 1, 1'b1,
                                  '{'0, '0, spq_pkg::ST_EMPTY, OCC_W'(0)}});
        directed_rows.push_back('{spq_pkg::OP_INSERT, '1, '1, 1, 1'b1,
                                  '{'0, '0, spq_pkg::ST_OK, OCC_W'(1)}});
        directed_rows.push_back('{spq_pkg::OP_INSERT, '0, '0, 1, 1'b1,
                                  '{'0, '0, spq_pkg::ST_OK, OCC_W'(2)}});
        directed_rows.push_back('{spq_pkg::OP_POP, '0, '0, 1, 1'b1,
                                  '{'0, '0, spq_pkg::ST_OK, OCC_W'(1)}});
        directed_rows.push_back('{spq_pkg::OP_POP, '0, '0, 1, 1'b1,
                                  '{'1, '1, spq_pkg::ST_OK, OCC_W'(0)}});
        directed_rows.push_back('{spq_pkg::OP_POP, '0, '0, 1, 1'b1,
                                  '{'0, '0, spq_pkg::ST_EMPTY, OCC_W'(0)}});
        // Equal weights: the newest of them must come out first.
        directed_rows.push_back('{spq_pkg::OP_INSERT, 32'h0001_0000, 32'h1111_0000,
                                  4, 1'b0, '0});
        directed_rows.push_back('{spq_pkg::OP_INSERT, 32'h0000_8000, 32'h2222_0000,
                                  1, 1'b0, '0});
        directed_rows.push_back('{spq_pkg::OP_INSERT, 32'h7FFF_FFFF, 32'hAAAA_AAAA,
                                  1, 1'b0, '0});
        directed_rows.push_back('{spq_pkg::OP_INSERT, 32'h8000_0000, 32'h5555_5555,
                                  1, 1'b0, '0});
        directed_rows.push_back('{spq_pkg::OP_POP, '0, '0, 3, 1'b0, '0});
        // Fill to the last free slot, then the last slot, then two dropped inserts.
        directed_rows.push_back('{spq_pkg::OP_INSERT, 32'h0001_0000, 32'h3333_0000,
                                  11, 1'b0, '0});
        directed_rows.push_back('{spq_pkg::OP_INSERT, '1, 32'h4444_0000, 1, 1'b0, '0});
        directed_rows.push_back('{spq_pkg::OP_INSERT, 32'h1234_5678, 32'h0BAD_F00D,
                                  2, 1'b1,
                                  '{'0, '0, spq_pkg::ST_FULL, OCC_W'(QDEPTH)}});
        // Empty it completely and pop once more past empty.
        directed_rows.push_back('{spq_pkg::OP_POP, '0, '0, QDEPTH, 1'b0, '0});
        directed_rows.push_back('{spq_pkg::OP_POP, '0, '0, 1, 1'b1,
                                  '{'0, '0, spq_pkg::ST_EMPTY, OCC_W'(0)}});
        directed_rows.push_back('{spq_pkg::OP_INSERT, '0, '1, 1, 1'b1,
                                  '{'0, '0, spq_pkg::ST_OK, OCC_W'(1)}});
        directed_rows.push_back('{spq_pkg::OP_INSERT, '1, '0, 1, 1'b1,
                                  '{'0, '0, spq_pkg::ST_OK, OCC_W'(2)}});
        directed_rows.push_back('{spq_pkg::OP_POP, '0, '0, 2, 1'b0, '0});

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[r]) begin
            row = directed_rows[r];
            for (int k = 0; k < row.reps; k++) begin
                send_item(row.op, row.weight, row.payload + PAY_W'(k), row.fixed,
                          row.result);
            end
        end
        drain_results();

        // Phase 1: no idling on either side.
        run_random(ITEMS_PER_PHASE, 1'b0);
        // Phase 2: the sender idles often; it also pauses once mid-phase until every
        // result is back.
        send_idle_pct = 64;
        run_random(ITEMS_PER_PHASE, 1'b1);
        // Phase 3: the receiver stalls often.
        send_idle_pct  = 0;
        recv_stall_pct = 64;
        run_random(ITEMS_PER_PHASE, 1'b0);
        // Phase 4: light idling on both sides.
        send_idle_pct  = 11;
        recv_stall_pct = 11;
        run_random(ITEMS_PER_PHASE, 1'b0);

        // Keep clocking so that any stray result would still be seen.
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (pending_results.size() != 0)
            report_error($sformatf("%0d expected results never arrived",
                                   pending_results.size()));

        $display("Run covered %0d inserts and %0d pops, %0d dropped on a full queue,",
                 insert_count, pop_count, full_count);
        $display("%0d pops on an empty queue, peak fill %0d, under four pressure phases.",
                 empty_count, peak_fill);
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue.sv
dv/sorted_priority_queue_tb.sv
